// ----- rtl/date_add_pkg.sv -----
// date_add_pkg: status codes, reciprocal constants and calendar helper functions
// shared by the date add-days pipeline (rtl/date_add_days_unit.sv)
// no dependencies
`default_nettype none

package date_add_pkg;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_DATE = 2'd1,
		ST_RANGE    = 2'd2
	} status_t;

	// year values handled by the helpers below (enough for years up to 131071)
	localparam int unsigned CAL_YR_W = 17;

	localparam int unsigned MONTHS    = 12;
	localparam int unsigned DAYS_YEAR = 365;

	// floor(x / 25) as (x * R25) >> R25_SHIFT, exact for x < 43690
	localparam logic [15:0] R25       = 16'd41944;
	localparam int unsigned R25_SHIFT = 20;

	// ceil(400 * 2^32 / 146097): years per day, scaled, rounded up
	localparam int unsigned YR_RECIP_W     = 24;
	localparam int unsigned YR_RECIP_SHIFT = 32;
	localparam logic [YR_RECIP_W-1:0] YR_RECIP =
		YR_RECIP_W'((64'd400 * (64'd1 << 32) + 64'd146096) / 64'd146097);

	// ceil(2^28 / 7) for day number mod 7, exact for values below 2^25
	localparam int unsigned WD_RECIP_W     = 26;
	localparam int unsigned WD_RECIP_SHIFT = 28;
	localparam logic [WD_RECIP_W-1:0] WD_RECIP =
		WD_RECIP_W'(((64'd1 << 28) + 64'd6) / 64'd7);

	function automatic logic [10:0] div25(input logic [14:0] x);
		logic [30:0] p;
		p = 31'(x) * 31'(R25);
		return p[30:20];
	endfunction

	function automatic logic is_leap(input logic [CAL_YR_W-1:0] y);
		logic [14:0] x;
		logic [10:0] q;
		logic [14:0] r;
		x = y[CAL_YR_W-1:2];
		q = div25(x);
		r = x - 15'(q) * 15'd25;
		// divisible by 4, and either not by 100 or also by 400
		return (y[1:0] == 2'd0) && ((r != 15'd0) || (y[3:2] == 2'd0));
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] m, input logic lp);
		logic [4:0] len;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			4'd2: len = lp ? 5'd29 : 5'd28;
			default: len = 5'd0;
		endcase
		return len;
	endfunction

	// days of the year before the first of month m
	function automatic logic [8:0] month_cum(input logic [3:0] m, input logic lp);
		logic [8:0] base;
		case (m)
			4'd1: base = 9'd0;
			4'd2: base = 9'd31;
			4'd3: base = 9'd59;
			4'd4: base = 9'd90;
			4'd5: base = 9'd120;
			4'd6: base = 9'd151;
			4'd7: base = 9'd181;
			4'd8: base = 9'd212;
			4'd9: base = 9'd243;
			4'd10: base = 9'd273;
			4'd11: base = 9'd304;
			4'd12: base = 9'd334;
			default: base = 9'd0;
		endcase
		return base + 9'((lp && (m > 4'd2)) ? 1 : 0);
	endfunction

endpackage

`default_nettype wire

// ----- rtl/date_add_days_unit.sv -----
// date_add_days_unit: adds a signed day count to a Gregorian date, nine-stage pipeline
// depends on rtl/date_add_pkg.sv
//
// A request is taken on every clock edge where start is high; busy is tied low since
// the pipeline never stalls. Each result comes out in order, on the result ports for
// one cycle with done high; the receiver must take it then. Throughput is one date
// per clock. The nine register stages are: date check and year quotients, day number,
// offset add and range check, year estimate by reciprocal multiply, candidate year
// quotients, candidate year start days, year pick, month search, day of month and
// output register. Status 1 flags an invalid start date, status 2 a result before
// 0001-01-01 or past the end of MAX_YEAR; on either the other result fields are zero.
`default_nettype none

module date_add_days_unit #(
	parameter int unsigned MAX_YEAR = 9999
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [13:0]        year_in,
	input  wire logic [3:0]         month_in,
	input  wire logic [4:0]         day_in,
	input  wire logic signed [22:0] day_offset,
	output logic                    done,
	output logic [13:0]             year_out,
	output logic [3:0]              month_out,
	output logic [4:0]              day_out,
	output logic [21:0]             day_number,
	output logic [2:0]              weekday,
	output logic                    leap_year,
	output logic [1:0]              status
);

	localparam int unsigned MAX_DN  = 365 * MAX_YEAR + MAX_YEAR / 4 - MAX_YEAR / 100
		+ MAX_YEAR / 400;
	localparam int unsigned DN_W    = $clog2(MAX_DN + 1);
	localparam int unsigned YR_W    = ($clog2(MAX_YEAR + 2) < 8) ? 8 : $clog2(MAX_YEAR + 2);
	localparam int unsigned START_W = 23;
	localparam int unsigned SUM_W   = ((DN_W > START_W) ? DN_W : START_W) + 2;
	localparam int unsigned DBW     = DN_W + 1;
	localparam int unsigned YP_W    = date_add_pkg::YR_RECIP_SHIFT + YR_W;
	localparam int unsigned WP_W    = DN_W + date_add_pkg::WD_RECIP_W;
	localparam int unsigned Q7_W    = DN_W - 2;
	localparam int unsigned LAT     = 9;
	localparam int unsigned CYW     = date_add_pkg::CAL_YR_W;

	// ---------------- stage 1: date check, year quotients
	logic                         v_s1;
	date_add_pkg::status_t        st_s1;
	logic [13:0]                  y1_s1;
	logic [10:0]                  q100_s1, q400_s1;
	logic [8:0]                   doy_s1;
	logic signed [22:0]           off_s1;

	logic [CYW-1:0]               yr_ext;
	logic                         lp_in;
	logic                         bad_in;
	logic [13:0]                  y1_c;

	assign busy = 1'b0;

	always_comb begin
		yr_ext = CYW'(year_in);
		lp_in  = date_add_pkg::is_leap(yr_ext);
		bad_in = (year_in == 14'd0) || (yr_ext > CYW'(MAX_YEAR)) || (month_in == 4'd0)
			|| (month_in > 4'(date_add_pkg::MONTHS)) || (day_in == 5'd0)
			|| (day_in > date_add_pkg::month_len(month_in, lp_in));
		y1_c   = year_in - 14'd1;
	end

	always_ff @(posedge clk) begin
		st_s1   <= bad_in ? date_add_pkg::ST_BAD_DATE : date_add_pkg::ST_OK;
		y1_s1   <= y1_c;
		q100_s1 <= date_add_pkg::div25(15'(y1_c >> 2));
		q400_s1 <= date_add_pkg::div25(15'(y1_c >> 4));
		doy_s1  <= date_add_pkg::month_cum(month_in, lp_in) + 9'(day_in);
		off_s1  <= day_offset;
	end

	// ---------------- stage 2: start day number
	logic                         v_s2;
	date_add_pkg::status_t        st_s2;
	logic [START_W-1:0]           dn0_s2;
	logic signed [22:0]           off_s2;

	always_ff @(posedge clk) begin
		st_s2  <= st_s1;
		dn0_s2 <= START_W'(y1_s1) * START_W'(date_add_pkg::DAYS_YEAR) + START_W'(y1_s1 >> 2)
			- START_W'(q100_s1) + START_W'(q400_s1) + START_W'(doy_s1);
		off_s2 <= off_s1;
	end

	// ---------------- stage 3: add offset, range check
	logic                         v_s3;
	date_add_pkg::status_t        st_s3;
	logic [DN_W-1:0]              dn_s3, n_s3;

	logic signed [SUM_W-1:0]      sum_c;
	logic                         out_rng;

	always_comb begin
		sum_c   = $signed(SUM_W'(dn0_s2)) + SUM_W'(off_s2);
		out_rng = (sum_c <= $signed(SUM_W'(0))) || (sum_c > $signed(SUM_W'(MAX_DN)));
	end

	always_ff @(posedge clk) begin
		if ((st_s2 == date_add_pkg::ST_OK) && out_rng) begin
			st_s3 <= date_add_pkg::ST_RANGE;
		end else begin
			st_s3 <= st_s2;
		end
		dn_s3 <= DN_W'(sum_c);
		n_s3  <= DN_W'(sum_c - $signed(SUM_W'(1)));
	end

	// ---------------- stage 4: year estimate (upper bound), weekday quotient
	logic                         v_s4;
	date_add_pkg::status_t        st_s4;
	logic [DN_W-1:0]              dn_s4, n_s4;
	logic [YR_W-1:0]              u_s4;
	logic [Q7_W-1:0]              q7_s4;

	logic [YP_W-1:0]              yprod;
	logic [WP_W-1:0]              wprod;

	always_comb begin
		// upper bound on full years elapsed: at most two above the true count
		yprod = YP_W'(DBW'(n_s3) + DBW'(2)) * YP_W'(date_add_pkg::YR_RECIP);
		wprod = WP_W'(dn_s3) * WP_W'(date_add_pkg::WD_RECIP);
	end

	always_ff @(posedge clk) begin
		st_s4 <= st_s3;
		dn_s4 <= dn_s3;
		n_s4  <= n_s3;
		u_s4  <= yprod[date_add_pkg::YR_RECIP_SHIFT +: YR_W];
		q7_s4 <= wprod[date_add_pkg::WD_RECIP_SHIFT +: Q7_W];
	end

	// ---------------- stage 5: century quotients of the two top candidates
	logic                         v_s5;
	date_add_pkg::status_t        st_s5;
	logic [DN_W-1:0]              dn_s5, n_s5;
	logic [2:0]                   wd_s5;
	logic [YR_W-1:0]              ua_s5;
	logic [10:0]                  qa100_s5, qa400_s5, qb100_s5, qb400_s5;

	logic [YR_W-1:0]              ub_c;

	assign ub_c = u_s4 - YR_W'(1);

	always_ff @(posedge clk) begin
		st_s5    <= st_s4;
		dn_s5    <= dn_s4;
		n_s5     <= n_s4;
		wd_s5    <= 3'(dn_s4 - DN_W'(q7_s4) * DN_W'(7));
		ua_s5    <= u_s4;
		qa100_s5 <= date_add_pkg::div25(15'(CYW'(u_s4) >> 2));
		qa400_s5 <= date_add_pkg::div25(15'(CYW'(u_s4) >> 4));
		qb100_s5 <= date_add_pkg::div25(15'(CYW'(ub_c) >> 2));
		qb400_s5 <= date_add_pkg::div25(15'(CYW'(ub_c) >> 4));
	end

	// ---------------- stage 6: start days of candidates, leap flags
	logic                         v_s6;
	date_add_pkg::status_t        st_s6;
	logic [DN_W-1:0]              dn_s6, n_s6;
	logic [2:0]                   wd_s6;
	logic [YR_W-1:0]              ua_s6;
	logic [DBW-1:0]               dba_s6, dbb_s6;
	logic                         lpa1_s6, lpa0_s6, lpb_s6;

	logic [YR_W-1:0]              ub5_c;

	assign ub5_c = ua_s5 - YR_W'(1);

	always_ff @(posedge clk) begin
		st_s6   <= st_s5;
		dn_s6   <= dn_s5;
		n_s6    <= n_s5;
		wd_s6   <= wd_s5;
		ua_s6   <= ua_s5;
		dba_s6  <= DBW'(ua_s5) * DBW'(date_add_pkg::DAYS_YEAR) + DBW'(ua_s5 >> 2)
			- DBW'(qa100_s5) + DBW'(qa400_s5);
		dbb_s6  <= DBW'(ub5_c) * DBW'(date_add_pkg::DAYS_YEAR) + DBW'(ub5_c >> 2)
			- DBW'(qb100_s5) + DBW'(qb400_s5);
		// calendar years U+1, U and U-1
		lpa1_s6 <= date_add_pkg::is_leap(CYW'(ua_s5) + CYW'(1));
		lpa0_s6 <= date_add_pkg::is_leap(CYW'(ua_s5));
		lpb_s6  <= date_add_pkg::is_leap(CYW'(ub5_c));
	end

	// ---------------- stage 7: pick the year, day of year
	logic                         v_s7;
	date_add_pkg::status_t        st_s7;
	logic [DN_W-1:0]              dn_s7;
	logic [2:0]                   wd_s7;
	logic [YR_W-1:0]              yr_s7;
	logic [8:0]                   doy_s7;
	logic                         lp_s7;

	logic [DBW-1:0]               dbc_c, base_c;
	logic [YR_W-1:0]              yr_c;
	logic                         lp_c;

	always_comb begin
		dbc_c = dbb_s6 - DBW'(date_add_pkg::DAYS_YEAR) - DBW'(lpb_s6);
		if (dba_s6 <= DBW'(n_s6)) begin
			base_c = dba_s6;
			yr_c   = ua_s6 + YR_W'(1);
			lp_c   = lpa1_s6;
		end else if (dbb_s6 <= DBW'(n_s6)) begin
			base_c = dbb_s6;
			yr_c   = ua_s6;
			lp_c   = lpa0_s6;
		end else begin
			base_c = dbc_c;
			yr_c   = ua_s6 - YR_W'(1);
			lp_c   = lpb_s6;
		end
	end

	always_ff @(posedge clk) begin
		st_s7  <= st_s6;
		dn_s7  <= dn_s6;
		wd_s7  <= wd_s6;
		yr_s7  <= yr_c;
		doy_s7 <= 9'(DBW'(n_s6) - base_c);
		lp_s7  <= lp_c;
	end

	// ---------------- stage 8: month search
	logic                         v_s8;
	date_add_pkg::status_t        st_s8;
	logic [DN_W-1:0]              dn_s8;
	logic [2:0]                   wd_s8;
	logic [YR_W-1:0]              yr_s8;
	logic [8:0]                   doy_s8;
	logic                         lp_s8;
	logic [3:0]                   mo_s8;

	logic [3:0]                   mcnt;

	always_comb begin
		mcnt = 4'd1;
		for (int i = 2; i <= 12; i++) begin
			if (date_add_pkg::month_cum(4'(i), lp_s7) <= doy_s7) begin
				mcnt = mcnt + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		st_s8  <= st_s7;
		dn_s8  <= dn_s7;
		wd_s8  <= wd_s7;
		yr_s8  <= yr_s7;
		doy_s8 <= doy_s7;
		lp_s8  <= lp_s7;
		mo_s8  <= mcnt;
	end

	// ---------------- stage 9: day of month, output register
	logic                         v_s9;
	date_add_pkg::status_t        st_s9;
	logic [13:0]                  yr_s9;
	logic [3:0]                   mo_s9;
	logic [4:0]                   day_s9;
	logic [21:0]                  dn_s9;
	logic [2:0]                   wd_s9;
	logic                         lp_s9;

	logic                         ok8;

	assign ok8 = (st_s8 == date_add_pkg::ST_OK);

	always_ff @(posedge clk) begin
		st_s9  <= st_s8;
		yr_s9  <= ok8 ? 14'(yr_s8) : 14'd0;
		mo_s9  <= ok8 ? mo_s8 : 4'd0;
		day_s9 <= ok8 ? 5'(doy_s8 - date_add_pkg::month_cum(mo_s8, lp_s8) + 9'd1) : 5'd0;
		dn_s9  <= ok8 ? 22'(dn_s8) : 22'd0;
		wd_s9  <= ok8 ? wd_s8 : 3'd0;
		lp_s9  <= ok8 && lp_s8;
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	assign done       = v_s9;
	assign year_out   = yr_s9;
	assign month_out  = mo_s9;
	assign day_out    = day_s9;
	assign day_number = dn_s9;
	assign weekday    = wd_s9;
	assign leap_year  = lp_s9;
	assign status     = 2'(st_s9);

	// ---------------- checks
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LAT done)
		else $error("request did not produce a result after the pipeline depth");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (st_s9 != date_add_pkg::ST_OK)) |-> ((year_out == 14'd0)
		&& (month_out == 4'd0) && (day_out == 5'd0) && (day_number == 22'd0)
		&& (weekday == 3'd0) && !leap_year))
		else $error("error result carries nonzero date fields");

	a_ok_date: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (st_s9 == date_add_pkg::ST_OK)) |-> ((year_out != 14'd0)
		&& (month_out != 4'd0) && (month_out <= 4'(date_add_pkg::MONTHS))
		&& (day_out != 5'd0) && (weekday <= 3'd6)))
		else $error("good result with impossible calendar fields");

	a_doy_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s8 && (st_s8 == date_add_pkg::ST_OK)) |->
		(doy_s8 < (lp_s8 ? 9'd366 : 9'd365)))
		else $error("year pick left a day of year past the end of the year");

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
// tb_top: self-checking bench for date_add_days_unit, with a scoreboard class that predicts
// each result from the accepted request and checks it field by field
// depends on rtl/date_add_pkg.sv and rtl/date_add_days_unit.sv
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_YEAR = 9999;
	localparam int ITEMS    = 700;

	class result_scoreboard;
		typedef struct {
			logic [13:0] year;
			logic [3:0]  month;
			logic [4:0]  day;
			logic [21:0] serial;
			logic [2:0]  wday;
			logic        leap;
			date_add_pkg::status_t st;
		} date_result_t;

		date_result_t expected_q[$];
		int errors;

		function new();
			errors = 0;
		endfunction

		function bit gregorian_leap(int y);
			return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
		endfunction

		function int month_days(int m, int y);
			case (m)
				4, 6, 9, 11: return 30;
				2: return gregorian_leap(y) ? 29 : 28;
				default: return 31;
			endcase
		endfunction

		function int days_before(int m, int y);
			int acc;
			acc = 0;
			for (int k = 1; k < m; k++)
				acc += month_days(k, y);
			return acc;
		endfunction

		// 0001-01-01 is day 1
		function int to_serial(int y, int m, int d);
			int p;
			p = y - 1;
			return p * 365 + p / 4 - p / 100 + p / 400 + days_before(m, y) + d;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function date_result_t predict(int y, int m, int d, int ofs);
			date_result_t r;
			int n, yr, mo, doy;
			r = '{year: '0, month: '0, day: '0, serial: '0, wday: '0, leap: 1'b0,
			      st: date_add_pkg::ST_OK};
			if (y == 0 || y > MAX_YEAR || m == 0 || m > 12 || d == 0 ||
			    d > month_days(m, y)) begin
				r.st = date_add_pkg::ST_BAD_DATE;
				return r;
			end
			n = to_serial(y, m, d) + ofs;
			// day 0 is out of range as well
			if (n < 1 || n > to_serial(MAX_YEAR, 12, 31)) begin
				r.st = date_add_pkg::ST_RANGE;
				return r;
			end
			yr = int'((longint'(n) * 400) / 146097);
			if (yr < 1)
				yr = 1;
			while (to_serial(yr + 1, 1, 1) <= n)
				yr++;
			while (to_serial(yr, 1, 1) > n)
				yr--;
			doy = n - to_serial(yr, 1, 1) + 1;
			mo = 1;
			while (mo < 12 && doy > days_before(mo + 1, yr))
				mo++;
			r.year   = 14'(yr);
			r.month  = 4'(mo);
			r.day    = 5'(doy - days_before(mo, yr));
			r.serial = 22'(n);
			r.wday   = 3'(n % 7);
			r.leap   = gregorian_leap(yr);
			return r;
		endfunction

		function void note_request(int y, int m, int d, int ofs);
			expected_q.push_back(predict(y, m, d, ofs));
		endfunction

		function void field_check(string name, int want, int got);
			if (want != got) begin
				$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_result(logic [13:0] y, logic [3:0] m, logic [4:0] d,
		                           logic [21:0] n, logic [2:0] wd, logic lp, logic [1:0] st);
			date_result_t e;
			if (expected_q.size() == 0) begin
				$display("%0t: result with no request pending, actual status %0d", $time, st);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			field_check("status", int'(e.st), int'(st));
			field_check("year_out", e.year, y);
			field_check("month_out", e.month, m);
			field_check("day_out", e.day, d);
			field_check("day_number", e.serial, n);
			field_check("weekday", e.wday, wd);
			field_check("leap_year", e.leap, lp);
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [13:0]        year_in;
	logic [3:0]         month_in;
	logic [4:0]         day_in;
	logic signed [22:0] day_offset;
	logic               done;
	logic [13:0]        year_out;
	logic [3:0]         month_out;
	logic [4:0]         day_out;
	logic [21:0]        day_number;
	logic [2:0]         weekday;
	logic               leap_year;
	logic [1:0]         status;

	result_scoreboard board;

	date_add_days_unit #(.MAX_YEAR(MAX_YEAR)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.year_in(year_in), .month_in(month_in), .day_in(day_in), .day_offset(day_offset),
		.done(done), .year_out(year_out), .month_out(month_out), .day_out(day_out),
		.day_number(day_number), .weekday(weekday), .leap_year(leap_year), .status(status)
	);

	initial begin
		clk = 1'b0;
	end

	always #5 clk = ~clk;

	// request accept and result check, both on pre-edge values
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				board.note_request(year_in, month_in, day_in, int'(day_offset));
			if (done)
				board.check_result(year_out, month_out, day_out, day_number, weekday,
				                   leap_year, status);
		end
	end

	task automatic send_request(input int y, input int m, input int d, input int ofs);
		start      <= 1'b1;
		year_in    <= 14'(y);
		month_in   <= 4'(m);
		day_in     <= 5'(d);
		day_offset <= 23'(ofs);
		do @(posedge clk); while (busy !== 1'b0);
	endtask

	// junk on the request fields while start is low
	task automatic idle(input int cycles);
		start      <= 1'b0;
		year_in    <= 14'($urandom);
		month_in   <= 4'($urandom);
		day_in     <= 5'($urandom);
		day_offset <= 23'($urandom);
		repeat (cycles) @(posedge clk);
	endtask

	task automatic send_random();
		int y, m, d, ofs, last, target;
		last = board.to_serial(MAX_YEAR, 12, 31);
		if ($urandom_range(0, 9) == 0) begin
			send_request($urandom_range(0, 16383), $urandom_range(0, 15), $urandom_range(0, 31),
			             int'($urandom));
			return;
		end
		case ($urandom_range(0, 7))
			0: y = $urandom_range(1, 4);
			1: y = $urandom_range(MAX_YEAR - 3, MAX_YEAR);
			2: y = 400 * $urandom_range(1, 24) + $urandom_range(0, 2) - 1;
			default: y = $urandom_range(1, MAX_YEAR);
		endcase
		m = $urandom_range(1, 12);
		d = ($urandom_range(0, 3) == 0) ? board.month_days(m, y)
		                                : $urandom_range(1, board.month_days(m, y));
		case ($urandom_range(0, 5))
			0, 1: ofs = $urandom_range(0, 1500) - 750;
			2, 3: ofs = $urandom_range(1, last) - board.to_serial(y, m, d);
			4: ofs = int'({{9{1'b0}}, 23'($urandom)} ^ 32'h0) - (($urandom & 1) ? 32'h0 : 0);
			default: begin
				case ($urandom_range(0, 5))
					0: target = 0;
					1: target = 1;
					2: target = 2;
					3: target = last - 1;
					4: target = last;
					default: target = last + 1;
				endcase
				ofs = target - board.to_serial(y, m, d);
			end
		endcase
		// sign extend 23-bit offsets from the wide random case
		ofs = int'(23'sh0 + $signed(23'(ofs)));
		send_request(y, m, d, ofs);
	endtask

	initial begin
		int sent, burst, guard;
		board      = new();
		arst_n     = 1'b0;
		start      = 1'b0;
		year_in    = '0;
		month_in   = '0;
		day_in     = '0;
		day_offset = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		idle(2);

		// calendar edges, range limits and invalid dates
		send_request(1, 1, 1, 0);
		send_request(1, 1, 1, -1);
		send_request(MAX_YEAR, 12, 31, 0);
		send_request(MAX_YEAR, 12, 31, 1);
		send_request(1, 1, 1, 4194303);
		send_request(MAX_YEAR, 12, 31, -4194304);
		send_request(1, 1, 1, 3652058);
		send_request(MAX_YEAR, 12, 31, -3652058);
		send_request(2000, 2, 29, 0);
		send_request(1900, 2, 29, 0);
		send_request(2001, 2, 29, 0);
		send_request(2024, 2, 29, 365);
		send_request(0, 6, 15, 0);
		send_request(10000, 1, 1, 0);
		send_request(16383, 15, 31, -1);
		send_request(2020, 0, 10, 0);
		send_request(2020, 13, 10, 0);
		send_request(2020, 5, 0, 0);
		send_request(2021, 4, 31, 0);
		send_request(2021, 12, 31, 0);
		send_request(1600, 12, 31, 1);
		send_request(1700, 12, 31, 1);
		send_request(2000, 12, 31, 1);
		send_request(4, 12, 31, 1);
		send_request(1999, 3, 1, -1);
		idle(3);

		sent = 0;
		while (sent < ITEMS) begin
			burst = $urandom_range(1, 30);
			repeat (burst) begin
				send_random();
				sent++;
			end
			if ($urandom_range(0, 3) != 0)
				idle($urandom_range(1, 8));
		end
		idle(1);

		guard = 0;
		while (board.pending() != 0 && guard < 1000) begin
			@(posedge clk);
			guard++;
		end
		repeat (20) @(posedge clk);
		if (board.errors == 0 && board.pending() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#2000000;
		$display("FAILURE");
		$finish;
	end

endmodule

`default_nettype wire

// ----- sim.f -----
rtl/date_add_pkg.sv
rtl/date_add_days_unit.sv
sim/tb_top.sv
